>>> sv/id3_text_field_to_utf8_core_assert.svh
// Assertion macros for the ID3 text field converter, used by its result buffer.
`ifndef ID3_TEXT_FIELD_TO_UTF8_CORE_ASSERT_SVH
`define ID3_TEXT_FIELD_TO_UTF8_CORE_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define ID3U_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("id3u: same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define ID3U_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("id3u: next-cycle check failed");

`endif

>>> sv/id3u_pkg.sv
// Shared types, codes and UTF-8 helpers for the ID3 text field converter.
package id3u_pkg;

  localparam int MAX_RESULTS = 5;

  // Result kinds
  localparam logic [1:0] KIND_TEXT = 2'd0;
  localparam logic [1:0] KIND_LANG = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  // Text encodings as held in the field state
  localparam logic [2:0] ENC_LATIN1    = 3'd0;
  localparam logic [2:0] ENC_UTF16_BOM = 3'd1;
  localparam logic [2:0] ENC_UTF16_BE  = 3'd2;
  localparam logic [2:0] ENC_UTF8      = 3'd3;
  localparam logic [2:0] ENC_RAW       = 3'd4;

  localparam logic [2:0] POS_MAX = 3'd7;

  // UTF-8 building blocks
  localparam logic [7:0] UTF8_CONT  = 8'h80;
  localparam logic [7:0] UTF8_LEAD2 = 8'hc0;
  localparam logic [7:0] UTF8_LEAD3 = 8'he0;
  localparam logic [7:0] UTF8_LEAD4 = 8'hf0;

  // UTF-16 units and code points
  localparam logic [15:0] BOM_BIG      = 16'hfeff;
  localparam logic [15:0] BOM_LITTLE   = 16'hfffe;
  localparam logic [5:0]  SURR_HIGH    = 6'b110110;
  localparam logic [5:0]  SURR_LOW     = 6'b110111;
  localparam logic [20:0] CP_REPLACE   = 21'h00fffd;
  localparam logic [20:0] CP_SUPP_BASE = 21'h010000;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
  } result_t;

  typedef struct packed {
    logic [2:0]                      count;
    result_t [MAX_RESULTS-1:0]       items;
  } batch_t;

  typedef struct packed {
    logic [2:0] pos;
    logic [2:0] encoding;
    logic       lang_found;
    logic [7:0] held_byte;
    logic       held_valid;
    logic       big_endian;
    logic       mark_checked;
    logic [9:0] pend_hi;
    logic       pend_valid;
  } field_state_t;

  // Append one result to a batch, dropping it once the batch is full.
  function automatic batch_t push(batch_t b, logic [7:0] v, logic [1:0] k);
    batch_t r;
    r = b;
    if (r.count < 3'(MAX_RESULTS)) begin
      r.items[r.count].data = v;
      r.items[r.count].kind = k;
      r.count = r.count + 3'd1;
    end
    return r;
  endfunction

  // Append the UTF-8 bytes of one code point, lead byte first.
  function automatic batch_t push_cp(batch_t b, logic [20:0] cp);
    batch_t r;
    r = b;
    if (cp < 21'h000080) begin
      r = push(r, cp[7:0], KIND_TEXT);
    end else if (cp < 21'h000800) begin
      r = push(r, UTF8_LEAD2 | {3'b0, cp[10:6]}, KIND_TEXT);
      r = push(r, UTF8_CONT | {2'b0, cp[5:0]}, KIND_TEXT);
    end else if (cp < 21'h010000) begin
      r = push(r, UTF8_LEAD3 | {4'b0, cp[15:12]}, KIND_TEXT);
      r = push(r, UTF8_CONT | {2'b0, cp[11:6]}, KIND_TEXT);
      r = push(r, UTF8_CONT | {2'b0, cp[5:0]}, KIND_TEXT);
    end else begin
      r = push(r, UTF8_LEAD4 | {5'b0, cp[20:18]}, KIND_TEXT);
      r = push(r, UTF8_CONT | {2'b0, cp[17:12]}, KIND_TEXT);
      r = push(r, UTF8_CONT | {2'b0, cp[11:6]}, KIND_TEXT);
      r = push(r, UTF8_CONT | {2'b0, cp[5:0]}, KIND_TEXT);
    end
    return r;
  endfunction

endpackage

>>> sv/id3u_if.sv
// Handshake channels of the ID3 text field converter: input, result and configuration.
interface id3u_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, in_byte, in_last, input ready);
  modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface id3u_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       out_last;
  modport source (output valid, out_byte, out_kind, out_last, input ready);
  modport sink   (input valid, out_byte, out_kind, out_last, output ready);
endinterface

interface id3u_cfg_if;
  logic valid;
  logic ready;
  logic language_present;
  modport source (output valid, language_present, input ready);
  modport sink   (input valid, language_present, output ready);
endinterface

>>> sv/id3u_convert.sv
// Per-byte conversion: next field state and the batch of results one byte causes.
module id3u_convert (
  input  id3u_pkg::field_state_t st,
  input  logic                   lang_enable,
  input  logic [7:0]             in_byte,
  input  logic                   in_last,
  output id3u_pkg::field_state_t st_next,
  output id3u_pkg::batch_t       batch
);

  logic        alpha;
  logic        lang_slot;
  logic [15:0] unit;
  logic        unit_low;
  logic        unit_high;

  // Classify the byte and assemble the UTF-16 unit in the current order
  assign alpha = ((in_byte >= 8'h41) && (in_byte <= 8'h5a)) ||
                 ((in_byte >= 8'h61) && (in_byte <= 8'h7a));
  assign lang_slot = ((st.pos == 3'd1) && lang_enable && alpha) ||
                     (st.lang_found && (st.pos <= 3'd3));
  assign unit = st.big_endian ? {st.held_byte, in_byte} : {in_byte, st.held_byte};
  assign unit_low  = (unit[15:10] == id3u_pkg::SURR_LOW);
  assign unit_high = (unit[15:10] == id3u_pkg::SURR_HIGH);

  // Work out the next state and the results for this beat
  always_comb begin
    logic mark_taken;
    st_next    = st;
    batch      = '0;
    mark_taken = 1'b0;

    if (st.pos == 3'd0) begin
      st_next.encoding     = (in_byte <= 8'd3) ? in_byte[2:0] : id3u_pkg::ENC_RAW;
      st_next.lang_found   = 1'b0;
      st_next.held_valid   = 1'b0;
      st_next.held_byte    = '0;
      st_next.pend_valid   = 1'b0;
      st_next.pend_hi      = '0;
      st_next.big_endian   = 1'b1;
      st_next.mark_checked = (st_next.encoding != id3u_pkg::ENC_UTF16_BOM);
      if (st_next.encoding == id3u_pkg::ENC_RAW) begin
        batch = id3u_pkg::push(batch, in_byte, id3u_pkg::KIND_TEXT);
      end
    end else if (lang_slot) begin
      st_next.lang_found = 1'b1;
      batch = id3u_pkg::push(batch, in_byte, id3u_pkg::KIND_LANG);
      if (st.encoding == id3u_pkg::ENC_RAW) begin
        batch = id3u_pkg::push(batch, in_byte, id3u_pkg::KIND_TEXT);
      end
    end else if (st.encoding == id3u_pkg::ENC_LATIN1) begin
      // Latin-1 drops the field's final byte
      if (!in_last) begin
        batch = id3u_pkg::push_cp(batch, {13'b0, in_byte});
      end
    end else if ((st.encoding == id3u_pkg::ENC_UTF16_BOM) ||
                 (st.encoding == id3u_pkg::ENC_UTF16_BE)) begin
      if (!st.held_valid) begin
        st_next.held_byte  = in_byte;
        st_next.held_valid = 1'b1;
      end else begin
        st_next.held_valid = 1'b0;
        // Check and drop a byte-order mark on the first unit
        if (!st.mark_checked) begin
          st_next.mark_checked = 1'b1;
          if (unit == id3u_pkg::BOM_BIG) begin
            st_next.big_endian = 1'b1;
            mark_taken         = 1'b1;
          end else if (unit == id3u_pkg::BOM_LITTLE) begin
            st_next.big_endian = 1'b0;
            mark_taken         = 1'b1;
          end
        end
        if (!mark_taken) begin
          if (st.pend_valid) begin
            st_next.pend_valid = 1'b0;
            if (unit_low) begin
              batch = id3u_pkg::push_cp(batch, id3u_pkg::CP_SUPP_BASE +
                                               {1'b0, st.pend_hi, unit[9:0]});
            end else begin
              batch = id3u_pkg::push_cp(batch, id3u_pkg::CP_REPLACE);
            end
          end else if (unit_high) begin
            st_next.pend_hi    = unit[9:0];
            st_next.pend_valid = 1'b1;
          end else if (unit_low) begin
            batch = id3u_pkg::push_cp(batch, id3u_pkg::CP_REPLACE);
          end else if (unit != 16'h0000) begin
            batch = id3u_pkg::push_cp(batch, {5'b0, unit});
          end
        end
      end
    end else begin
      batch = id3u_pkg::push(batch, in_byte, id3u_pkg::KIND_TEXT);
    end

    // Advance the saturating position
    if (st.pos < id3u_pkg::POS_MAX) begin
      st_next.pos = st.pos + 3'd1;
    end

    // Close the field: flush a lone high surrogate, add the end marker
    if (in_last) begin
      if (st_next.pend_valid) begin
        batch = id3u_pkg::push_cp(batch, id3u_pkg::CP_REPLACE);
      end
      batch   = id3u_pkg::push(batch, 8'h00, id3u_pkg::KIND_END);
      st_next = '0;
    end
  end

endmodule

>>> sv/id3u_result_buf.sv
// Result buffer: holds one beat's batch and hands it out one result per cycle while the output is ready.
`include "id3_text_field_to_utf8_core_assert.svh"

module id3u_result_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  id3u_pkg::batch_t  batch,
  output logic              free,
  id3u_out_if.source        out_ch
);

  id3u_pkg::result_t [id3u_pkg::MAX_RESULTS-1:0] items;
  logic [2:0] cnt;
  logic [2:0] idx;
  logic       pop;
  logic       take;
  logic [3:0] fill;

  assign pop  = out_ch.valid && out_ch.ready;
  assign take = load && (batch.count != 3'd0);
  assign free = (cnt == 3'd0) || ((cnt == 3'd1) && out_ch.ready);
  assign fill = {1'b0, idx} + {1'b0, cnt};

  // Present the head result
  assign out_ch.valid    = (cnt != 3'd0);
  assign out_ch.out_byte = items[idx].data;
  assign out_ch.out_kind = items[idx].kind;
  assign out_ch.out_last = (cnt == 3'd1);

  // Count and index: load a new batch or advance past the taken result
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      idx <= '0;
    end else if (take) begin
      cnt <= batch.count;
      idx <= '0;
    end else if (pop) begin
      cnt <= cnt - 3'd1;
      idx <= idx + 3'd1;
    end
  end

  // Hold the payload of the batch
  always_ff @(posedge clk) begin
    if (take) begin
      items <= batch.items;
    end
  end

  `ID3U_ASSERT_NOW(a_load_only_free, clk, rst, load, free)
  `ID3U_ASSERT_NOW(a_fill_bound, clk, rst, 1'b1, fill <= 4'(id3u_pkg::MAX_RESULTS))
  `ID3U_ASSERT_NEXT(a_pop_counts, clk, rst, pop && !take, cnt == $past(cnt) - 3'd1)
  `ID3U_ASSERT_NEXT(a_take_loads, clk, rst, take, (cnt == $past(batch.count)) && (idx == 3'd0))

endmodule

>>> sv/id3_text_field_to_utf8_core.sv
// Top level of the ID3 text field to UTF-8 converter.
// Takes one byte of an ID3v2 text field per input beat (the first byte picks the encoding)
// and gives UTF-8 text bytes, language letters and one end marker per field. Each input
// beat is converted combinationally into a batch of zero to five results held in the
// result buffer, which hands out one result per cycle while the output is ready. A new
// byte is taken in the cycle its predecessor's last result leaves, so bytes giving at most
// one result each sustain one byte per cycle while the output is ready; a byte giving n
// results (four for a completed surrogate pair, five with the end marker) holds off the
// next byte until its last result leaves, and one giving none (encoding byte, first half
// of a UTF-16 unit) does not. The language register has its own channel, always ready.
module id3_text_field_to_utf8_core (
  input  logic        clk,
  input  logic        rst,
  id3u_in_if.sink     in_ch,
  id3u_out_if.source  out_ch,
  id3u_cfg_if.sink    cfg_ch
);

  id3u_pkg::field_state_t st;
  id3u_pkg::field_state_t st_next;
  id3u_pkg::batch_t       batch;
  logic                   language_present;
  logic                   buf_free;
  logic                   accept;

  assign in_ch.ready  = buf_free;
  assign accept       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      language_present <= 1'b0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      language_present <= cfg_ch.language_present;
    end
  end

  // Field state: advance on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  id3u_convert u_convert (
    .st          (st),
    .lang_enable (language_present),
    .in_byte     (in_ch.in_byte),
    .in_last     (in_ch.in_last),
    .st_next     (st_next),
    .batch       (batch)
  );

  id3u_result_buf u_result_buf (
    .clk    (clk),
    .rst    (rst),
    .load   (accept),
    .batch  (batch),
    .free   (buf_free),
    .out_ch (out_ch)
  );

endmodule
